// ----- rtl/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg: shared definitions for the cursor list editor
// Sizes, command and status codes, controller states and the structs that
// pass between the controller, the element memory and the output register.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // Wide enough for a signed cursor plus a signed 32-bit offset.
   localparam int WIDE_W   = 34;

   localparam int ARG_W    = 32;
   localparam int FIELD_W  = 11;
   localparam int RSP_W    = 56;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_MOVE   = 2'd1;
   localparam logic [1:0] CMD_ERASE  = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_AT_END = 2'd2;
   localparam logic [1:0] STATUS_RANGE  = 2'd3;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_EXEC,
      STATE_MOVE,
      STATE_RESULT
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ARG_W-1:0]  wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] list_length;
      logic [FIELD_W-1:0] cursor_position;
      logic [ARG_W-1:0]   read_value;
   } result_type;

endpackage

// ----- rtl/cursor_list_editor.sv -----
// ----------------------------------------------------------------------------
// cursor_list_editor: ordered list of signed values with an editing cursor
// Gap buffer in one dual-port RAM with a controller and an output register.
// ----------------------------------------------------------------------------
// One item is taken at a time and each gives exactly one result item. Insert,
// erase and read pass from acceptance through the execute state and the result
// state, where the result is loaded into the output register once that is free,
// and the block is ready for the next item when it is back in idle. A move
// passes through the execute state, then the move state, where the elements
// crossing the gap are copied one per cycle through the RAM's read and write
// ports, and then the result state. The next item is accepted while the
// previous result still waits in the output register. Out-of-reset the list is
// empty and no memory clearing is needed.
module cursor_list_editor (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,  // [31:0] argument
   input  logic [1:0]                req_tuser,  // [1:0] cmd
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [10:0] list_length, [21:11] cursor_position, [53:22] read_value, [55:54] zero
   output logic [cle_pkg::RSP_W-1:0] rsp_tdata,
   output logic [1:0]                rsp_tuser   // [1:0] status
);
   import cle_pkg::*;

   mem_req_type      mem_req;
   logic [ARG_W-1:0] mem_rdata;
   logic             out_free;
   logic             out_load;
   result_type       out_result;

   cle_ram #(
      .WIDTH (ARG_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   cle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_arg     (req_tdata),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_result (out_result)
   );

   cle_outreg u_outreg (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .result     (out_result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/cle_ram.sv -----
// ----------------------------------------------------------------------------
// cle_ram: generic simple dual-port RAM
// One write port and one read port, read data registered. The read register
// holds its value while no read is issued.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/cle_ctrl.sv -----
// ----------------------------------------------------------------------------
// cle_ctrl: gap buffer controller
// Elements before the cursor sit at the bottom of the memory, elements from
// the cursor onwards at the top; the gap lies between. Moves copy elements
// across the gap one per cycle.
// ----------------------------------------------------------------------------
module cle_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [1:0]               in_cmd,
   input  logic [cle_pkg::ARG_W-1:0] in_arg,
   output cle_pkg::mem_req_type     mem_req,
   input  logic [cle_pkg::ARG_W-1:0] mem_rdata,
   input  logic                     out_free,
   output logic                     out_load,
   output cle_pkg::result_type      out_result
);
   import cle_pkg::*;

   state_type                state_ff, state_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic signed [ARG_W-1:0]  arg_ff, arg_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         cursor_ff, cursor_in;
   logic [1:0]               status_ff, status_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic [ADDR_W-1:0]        src_ff, src_in;
   logic [ADDR_W-1:0]        dst_ff, dst_in;
   logic                     fwd_ff, fwd_in;
   logic                     wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]        wr_addr_ff, wr_addr_in;

   logic [CNT_W-1:0]         gap;
   logic                     full;
   logic                     read_ok;
   logic signed [WIDE_W-1:0] target;
   logic [CNT_W-1:0]         target_c;
   logic                     target_range;
   logic                     accept;

   assign accept = in_valid && in_ready;
   assign gap    = CNT_W'(CAPACITY) - count_ff;
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign read_ok = !arg_ff[ARG_W-1] && ({2'b00, arg_ff} < WIDE_W'(count_ff));

   // Clamp the move target to the ends of the list.
   always_comb begin
      target = $signed(WIDE_W'(cursor_ff)) + WIDE_W'(arg_ff);
      target_c = CNT_W'(target);
      target_range = 1'b0;
      if (target < 0) begin
         target_c = '0;
         target_range = 1'b1;
      end else if (target > $signed(WIDE_W'(count_ff))) begin
         target_c = count_ff;
         target_range = 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            if (cmd_ff == CMD_MOVE) begin
               state_in = STATE_MOVE;
            end else begin
               state_in = STATE_RESULT;
            end
         end
         STATE_MOVE: begin
            if (remain_ff == '0) begin
               state_in = STATE_RESULT;
            end
         end
         STATE_RESULT: begin
            if (out_free) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cmd_in     = cmd_ff;
      arg_in     = arg_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      status_in  = status_ff;
      remain_in  = remain_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      fwd_in     = fwd_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      in_ready   = 1'b0;
      out_load   = 1'b0;

      // A pending copy write lands in the cycle after its read was issued.
      mem_req.we    = wr_pend_ff;
      mem_req.waddr = wr_addr_ff;
      mem_req.wdata = mem_rdata;
      mem_req.re    = 1'b0;
      mem_req.raddr = src_ff;

      out_result.status          = status_ff;
      out_result.list_length     = FIELD_W'(count_ff);
      out_result.cursor_position = FIELD_W'(cursor_ff);
      out_result.read_value      = (cmd_ff == CMD_READ && status_ff == STATUS_OK) ?
                                   mem_rdata : '0;

      unique case (state_ff)
         STATE_IDLE: begin
            in_ready = 1'b1;
            if (accept) begin
               cmd_in = in_cmd;
               arg_in = in_arg;
            end
         end
         STATE_EXEC: begin
            status_in = STATUS_OK;
            unique case (cmd_ff)
               CMD_INSERT: begin
                  // The new element heads the upper part of the buffer.
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = ADDR_W'(gap + cursor_ff - CNT_W'(1));
                     mem_req.wdata = arg_ff;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
               CMD_ERASE: begin
                  // Dropping the head of the upper part widens the gap.
                  if (cursor_ff == count_ff) begin
                     status_in = STATUS_AT_END;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               CMD_READ: begin
                  if (read_ok) begin
                     mem_req.re = 1'b1;
                     if ({2'b00, arg_ff} < WIDE_W'(cursor_ff)) begin
                        mem_req.raddr = arg_ff[ADDR_W-1:0];
                     end else begin
                        mem_req.raddr = arg_ff[ADDR_W-1:0] + gap[ADDR_W-1:0];
                     end
                  end else begin
                     status_in = STATUS_RANGE;
                  end
               end
               CMD_MOVE: begin
                  if (target_range) begin
                     status_in = STATUS_RANGE;
                  end
                  cursor_in = target_c;
                  if (target_c > cursor_ff) begin
                     fwd_in    = 1'b1;
                     remain_in = target_c - cursor_ff;
                     src_in    = ADDR_W'(cursor_ff + gap);
                     dst_in    = ADDR_W'(cursor_ff);
                  end else begin
                     fwd_in    = 1'b0;
                     remain_in = cursor_ff - target_c;
                     src_in    = ADDR_W'(cursor_ff - CNT_W'(1));
                     dst_in    = ADDR_W'(cursor_ff - CNT_W'(1) + gap);
                  end
               end
               default: status_in = STATUS_OK;
            endcase
         end
         STATE_MOVE: begin
            if (remain_ff != '0) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = src_ff;
               wr_pend_in    = 1'b1;
               wr_addr_in    = dst_ff;
               remain_in     = remain_ff - CNT_W'(1);
               if (fwd_ff) begin
                  src_in = src_ff + ADDR_W'(1);
                  dst_in = dst_ff + ADDR_W'(1);
               end else begin
                  src_in = src_ff - ADDR_W'(1);
                  dst_in = dst_ff - ADDR_W'(1);
               end
            end
         end
         STATE_RESULT: begin
            out_load = out_free;
         end
         default: in_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= STATE_IDLE;
         count_ff   <= '0;
         cursor_ff  <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      arg_ff     <= arg_in;
      status_ff  <= status_in;
      remain_ff  <= remain_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      fwd_ff     <= fwd_in;
      wr_addr_ff <= wr_addr_in;
   end

endmodule

// ----- rtl/cle_outreg.sv -----
// ----------------------------------------------------------------------------
// cle_outreg: result output register
// Holds one finished result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module cle_outreg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  cle_pkg::result_type       result,
   output logic                      free,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [cle_pkg::RSP_W-1:0] rsp_tdata,
   output logic [1:0]                rsp_tuser
);
   import cle_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.status;
   assign rsp_tdata  = {2'b00, data_ff.read_value, data_ff.cursor_position,
                        data_ff.list_length};

endmodule

// ----- rtl/cle_checker.sv -----
// ----------------------------------------------------------------------------
// cle_checker: port-level assertions for the cursor list editor
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module cle_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [cle_pkg::RSP_W-1:0] rsp_tdata,
   input logic [1:0]                rsp_tuser
);
   import cle_pkg::*;

   logic [FIELD_W-1:0] rsp_length;
   logic [FIELD_W-1:0] rsp_cursor;
   logic [ARG_W-1:0]   rsp_value;
   logic               fields_exact;

   assign rsp_length   = rsp_tdata[FIELD_W-1:0];
   assign rsp_cursor   = rsp_tdata[2*FIELD_W-1:FIELD_W];
   assign rsp_value    = rsp_tdata[2*FIELD_W+ARG_W-1:2*FIELD_W];
   // The length and cursor fields are only exact while they cannot wrap.
   assign fields_exact = (CAPACITY < 2048);

   // A result waiting for the downstream side stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // The cursor never lies beyond the end and the list never exceeds its capacity.
   a_rsp_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && fields_exact |->
      rsp_cursor <= rsp_length && rsp_length <= FIELD_W'(CAPACITY))
      else $error("result cursor or length out of bounds");

   // Only a successful command may carry a non-zero value.
   a_rsp_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_value == '0)
      else $error("read value set on a refused or clamped command");

   // A refused insert can only happen on a full list.
   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL && fields_exact |->
      rsp_length == FIELD_W'(CAPACITY))
      else $error("insert refused on a list that is not full");

   // No result item is offered straight after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind cursor_list_editor cle_checker u_checker (.*);
